// File: sv/indexed_list_insert_remove_core_defines.svh
// assertion macros for the indexed list core and its checker
// no dependencies; included by the checker file
`ifndef INDEXED_LIST_INSERT_REMOVE_CORE_DEFINES_SVH
`define INDEXED_LIST_INSERT_REMOVE_CORE_DEFINES_SVH

// clocked property, masked while reset is held
`define ILIR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen at a clock edge
`define ILIR_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: sv/ilir_pkg.sv
// shared types and constants for the indexed list core
// no dependencies; imported by every module of the block
package ilir_pkg;

  localparam int DEF_CAPACITY = 16;

  localparam int OPC_W       = 2;
  localparam int POS_W       = 5;
  localparam int VAL_W       = 32;
  localparam int CNT_W       = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [OPC_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_INSERT = 2'd2,
    OP_REMOVE = 2'd3
  } opcode_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

// File: sv/indexed_list_insert_remove_core.sv
// an accepted item is latched, run in S_EXEC, and its result registered on out_tvalid
// the controller's accept/execute loop takes no new item while one is executing;
// a new item is taken once the previous result is gone or while it is being handed over
// entries from the target up shift in the execute cycle, one multiplexer per entry
// reset: list count cleared, result channel empty; entry contents are not cleared
module indexed_list_insert_remove_core
  import ilir_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [1:0] opcode, [6:2] position, [38:7] value, [39] unused
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] ok, [5:1] count, [7:6] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  ctrl_cmd_t cmd;

  ilir_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  ilir_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

endmodule

// File: sv/ilir_ctrl.sv
// controller for the indexed list core: accept, execute, result handshake
// depends on ilir_pkg
module ilir_ctrl
  import ilir_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  output ctrl_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign cmd.load   = in_tvalid && in_tready;
  assign cmd.exec   = (state_r == S_EXEC);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: sv/ilir_dp.sv
// datapath for the indexed list core: item latch, entry shifter, fill, result
// depends on ilir_pkg
module ilir_dp
  import ilir_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ctrl_cmd_t              cmd,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int FW = $clog2(CAPACITY + 1);
  localparam int CW = (FW > CNT_W) ? FW : CNT_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  opcode_t                  op_r;
  logic [POS_W-1:0]         pos_r;
  logic signed [VAL_W-1:0]  val_r;
  logic [FW-1:0]            fill_r, fill_nxt;
  logic signed [VAL_W-1:0]  ent_r   [CAPACITY];
  logic signed [VAL_W-1:0]  ent_nxt [CAPACITY];
  logic                     ok_r;
  logic [CNT_W-1:0]         cnt_r;

  logic [CW-1:0] fill_w, pos_w, tgt_w, cnt_w;
  logic          is_ins, ins_ok, rem_ok, pop_ok;

  assign fill_w = CW'(fill_r);
  assign pos_w  = CW'(pos_r);
  assign is_ins = (op_r == OP_PUSH) || (op_r == OP_INSERT);
  assign tgt_w  = (op_r == OP_PUSH) ? fill_w : pos_w;
  assign ins_ok = is_ins && (tgt_w <= fill_w) && (fill_w != CAP_C);
  assign rem_ok = (op_r == OP_REMOVE) && (pos_w < fill_w);
  assign pop_ok = (op_r == OP_POP) && (fill_r != '0);

  always_comb begin
    fill_nxt = fill_r;
    unique case (op_r) inside
      OP_PUSH, OP_INSERT: if (ins_ok) fill_nxt = fill_r + FW'(1);
      OP_POP:             if (pop_ok) fill_nxt = fill_r - FW'(1);
      OP_REMOVE:          if (rem_ok) fill_nxt = fill_r - FW'(1);
      default:            fill_nxt = fill_r;
    endcase
  end

  assign cnt_w = CW'(fill_nxt);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_ent
    localparam logic [CW-1:0] IDX = CW'(i);
    logic signed [VAL_W-1:0] below, above;
    if (i > 0) begin : g_below
      assign below = ent_r[i-1];
    end else begin : g_below0
      assign below = '0;
    end
    if (i < CAPACITY - 1) begin : g_above
      assign above = ent_r[i+1];
    end else begin : g_above0
      assign above = '0;
    end
    always_comb begin
      ent_nxt[i] = ent_r[i];
      if (ins_ok) begin
        if (IDX == tgt_w) begin
          ent_nxt[i] = val_r;
        end else if (IDX > tgt_w) begin
          ent_nxt[i] = below;
        end
      end else if (rem_ok && (IDX >= pos_w)) begin
        ent_nxt[i] = above;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.exec) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= opcode_t'(in_tdata[OPC_W-1:0]);
      pos_r <= in_tdata[OPC_W +: POS_W];
      val_r <= in_tdata[OPC_W+POS_W +: VAL_W];
    end
    if (cmd.exec) begin
      ok_r  <= ins_ok || rem_ok || pop_ok;
      cnt_r <= cnt_w[CNT_W-1:0];
      for (int i = 0; i < CAPACITY; i++) begin
        ent_r[i] <= ent_nxt[i];
      end
    end
  end

  assign out_tdata = {{(OUT_TDATA_W-CNT_W-1){1'b0}}, cnt_r, ok_r};

endmodule

// File: sv/ilir_checker.sv
// port-level checks for the indexed list core, bound to the top level
// depends on ilir_pkg and indexed_list_insert_remove_core_defines.svh
`include "indexed_list_insert_remove_core_defines.svh"

module ilir_checker
  import ilir_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [CNT_W-1:0] last_cnt_r;
  logic [1:0]       pend_r;
  logic             in_beat, out_beat;
  logic [CNT_W-1:0] cnt;

  assign in_beat  = in_tvalid && in_tready;
  assign out_beat = out_tvalid && out_tready;
  assign cnt      = out_tdata[CNT_W:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_cnt_r <= '0;
      pend_r     <= '0;
    end else begin
      if (out_beat) begin
        last_cnt_r <= cnt;
      end
      if (in_beat && !out_beat) begin
        pend_r <= pend_r + 2'd1;
      end else if (!in_beat && out_beat && pend_r != 2'd0) begin
        pend_r <= pend_r - 2'd1;
      end
    end
  end

  // rejected item leaves the count alone
  `ILIR_ASSERT(a_reject_keeps_count, out_tvalid && !out_tdata[0] |-> cnt == last_cnt_r, "rejected item changed count")
  // done item moves the count by exactly one
  `ILIR_ASSERT(a_ok_steps_count, out_tvalid && out_tdata[0] |-> (cnt == last_cnt_r + 5'd1) || (cnt == last_cnt_r - 5'd1), "count moved by other than one")
  // at most one item in flight, and no result without one
  `ILIR_NEVER(a_no_orphan_result, out_tvalid && pend_r == 2'd0, "result beat without an accepted item")
  `ILIR_NEVER(a_one_in_flight, pend_r[1], "more than one item in flight")
  // stalled result holds
  `ILIR_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

endmodule

bind indexed_list_insert_remove_core ilir_checker u_ilir_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
